FILE: rtl/slcp_pkg.sv
// Package of types, constants and opcodes shared by the sound-log command parser.
`timescale 1ns / 1ps

package slcp_pkg;

    localparam int BYTE_W        = 8;
    localparam int WAIT_W        = 16;
    localparam int TOTAL_W       = 32;
    localparam int KIND_W        = 2;
    localparam int QUEUE_DEPTH_D = 2;

    // Opcode decoding.
    localparam logic [BYTE_W-1:0] OP_SHORT_MASK  = 8'hF0;
    localparam logic [BYTE_W-1:0] OP_SHORT_WAIT  = 8'h70;
    localparam logic [BYTE_W-1:0] OP_NIBBLE_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] OP_WAIT_N      = 8'h61;
    localparam logic [BYTE_W-1:0] OP_WAIT_NTSC   = 8'h62;
    localparam logic [BYTE_W-1:0] OP_WAIT_PAL    = 8'h63;
    localparam logic [BYTE_W-1:0] OP_END         = 8'h66;
    localparam logic [BYTE_W-1:0] OP_REG_WRITE   = 8'hA0;

    localparam logic [WAIT_W-1:0] WAIT_NTSC_SAMPLES = 16'd735;
    localparam logic [WAIT_W-1:0] WAIT_PAL_SAMPLES  = 16'd882;

    typedef enum logic [KIND_W-1:0] {
        KIND_WAIT      = 2'd0,
        KIND_REG_WRITE = 2'd1,
        KIND_END       = 2'd2,
        KIND_BAD_OP    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_OPCODE = 3'd0,
        PH_CNT_LO = 3'd1,
        PH_CNT_HI = 3'd2,
        PH_ADDR   = 3'd3,
        PH_VALUE  = 3'd4
    } t_phase;

    // A decoded command as it travels from the front end to the back end.
    typedef struct packed {
        t_kind               kind;
        logic [WAIT_W-1:0]   wait_samples;
        logic [BYTE_W-1:0]   reg_addr;
        logic [BYTE_W-1:0]   reg_value;
        logic [BYTE_W-1:0]   bad_opcode;
    } t_cmd;

    // Status of the front end.
    typedef struct packed {
        logic   stopped;
        t_phase phase;
    } t_front_stat;

endpackage

FILE: rtl/slcp_in_if.sv
// Valid/ready channel that carries one byte of the command stream.
`timescale 1ns / 1ps

interface slcp_in_if;
    logic                          valid;
    logic                          ready;
    logic [slcp_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: rtl/slcp_out_if.sv
// Valid/ready channel that carries one decoded event of the parser.
`timescale 1ns / 1ps

interface slcp_out_if;
    logic                          valid;
    logic                          ready;
    logic [slcp_pkg::KIND_W-1:0]   event_kind;
    logic [slcp_pkg::WAIT_W-1:0]   wait_samples;
    logic [slcp_pkg::BYTE_W-1:0]   reg_addr;
    logic [slcp_pkg::BYTE_W-1:0]   reg_value;
    logic [slcp_pkg::TOTAL_W-1:0]  delay_total;
    logic [slcp_pkg::BYTE_W-1:0]   bad_opcode;

    modport source (output valid, output event_kind, output wait_samples, output reg_addr,
                    output reg_value, output delay_total, output bad_opcode, input ready);
    modport sink   (input valid, input event_kind, input wait_samples, input reg_addr,
                    input reg_value, input delay_total, input bad_opcode, output ready);
endinterface

FILE: rtl/slcp_front.sv
// Front end: takes bytes, tracks the parse phase and pushes decoded commands.
`timescale 1ns / 1ps

module slcp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    slcp_in_if.sink               i_byte,
    input  logic                  i_q_full,
    output logic                  o_push,
    output slcp_pkg::t_cmd        o_cmd,
    output slcp_pkg::t_front_stat o_stat
);

    slcp_pkg::t_phase                r_phase, n_phase;
    logic [slcp_pkg::BYTE_W-1:0]     r_held, n_held;
    logic                            r_stopped, n_stopped;
    logic [slcp_pkg::BYTE_W-1:0]     b;
    logic                            accept;

    // Once stopped, bytes are swallowed without needing queue space.
    assign i_byte.ready = r_stopped || !i_q_full;
    assign accept       = i_byte.valid && i_byte.ready;
    assign b            = i_byte.data_byte;
    assign o_stat       = '{stopped: r_stopped, phase: r_phase};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= slcp_pkg::PH_OPCODE;
            r_held    <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_held    <= n_held;
            r_stopped <= n_stopped;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        n_stopped = r_stopped;
        o_push    = 1'b0;
        o_cmd     = '0;
        if (accept && !r_stopped) begin
            unique case (r_phase)
                slcp_pkg::PH_CNT_LO: begin
                    n_held  = b;
                    n_phase = slcp_pkg::PH_CNT_HI;
                end
                slcp_pkg::PH_CNT_HI: begin
                    n_phase            = slcp_pkg::PH_OPCODE;
                    o_push             = 1'b1;
                    o_cmd.kind         = slcp_pkg::KIND_WAIT;
                    o_cmd.wait_samples = {b, r_held};
                end
                slcp_pkg::PH_ADDR: begin
                    n_held  = b;
                    n_phase = slcp_pkg::PH_VALUE;
                end
                slcp_pkg::PH_VALUE: begin
                    n_phase         = slcp_pkg::PH_OPCODE;
                    o_push          = 1'b1;
                    o_cmd.kind      = slcp_pkg::KIND_REG_WRITE;
                    o_cmd.reg_addr  = r_held;
                    o_cmd.reg_value = b;
                end
                default: begin
                    n_phase = slcp_pkg::PH_OPCODE;
                    priority if ((b & slcp_pkg::OP_SHORT_MASK) == slcp_pkg::OP_SHORT_WAIT) begin
                        o_push             = 1'b1;
                        o_cmd.kind         = slcp_pkg::KIND_WAIT;
                        o_cmd.wait_samples = slcp_pkg::WAIT_W'(b & slcp_pkg::OP_NIBBLE_MASK)
                                             + slcp_pkg::WAIT_W'(1);
                    end else begin
                        unique case (b)
                            slcp_pkg::OP_WAIT_N: begin
                                n_phase = slcp_pkg::PH_CNT_LO;
                            end
                            slcp_pkg::OP_WAIT_NTSC: begin
                                o_push             = 1'b1;
                                o_cmd.kind         = slcp_pkg::KIND_WAIT;
                                o_cmd.wait_samples = slcp_pkg::WAIT_NTSC_SAMPLES;
                            end
                            slcp_pkg::OP_WAIT_PAL: begin
                                o_push             = 1'b1;
                                o_cmd.kind         = slcp_pkg::KIND_WAIT;
                                o_cmd.wait_samples = slcp_pkg::WAIT_PAL_SAMPLES;
                            end
                            slcp_pkg::OP_END: begin
                                n_stopped  = 1'b1;
                                o_push     = 1'b1;
                                o_cmd.kind = slcp_pkg::KIND_END;
                            end
                            slcp_pkg::OP_REG_WRITE: begin
                                n_phase = slcp_pkg::PH_ADDR;
                            end
                            default: begin
                                n_stopped        = 1'b1;
                                o_push           = 1'b1;
                                o_cmd.kind       = slcp_pkg::KIND_BAD_OP;
                                o_cmd.bad_opcode = b;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

endmodule

FILE: rtl/slcp_queue.sv
// Short first-in first-out queue of decoded commands between front and back end.
`timescale 1ns / 1ps

module slcp_queue #(
    parameter int DEPTH = slcp_pkg::QUEUE_DEPTH_D
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  slcp_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output slcp_pkg::t_cmd  o_cmd,
    output logic            o_full,
    output logic            o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    slcp_pkg::t_cmd     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/slcp_back.sv
// Back end: accumulates the saturating delay total and holds the output event register.
`timescale 1ns / 1ps

module slcp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  slcp_pkg::t_cmd  i_cmd,
    input  logic            i_empty,
    output logic            o_pop,
    slcp_out_if.source      o_event
);

    logic                              r_valid, n_valid;
    logic [slcp_pkg::TOTAL_W-1:0]      r_sum, n_sum;
    slcp_pkg::t_cmd                    r_cmd;
    logic [slcp_pkg::TOTAL_W:0]        sum_wide;

    assign o_pop    = !i_empty && (!r_valid || o_event.ready);
    assign sum_wide = {1'b0, r_sum} + (slcp_pkg::TOTAL_W + 1)'(i_cmd.wait_samples);

    always_comb begin
        n_valid = r_valid;
        n_sum   = r_sum;
        if (o_pop) begin
            n_valid = 1'b1;
            n_sum   = sum_wide[slcp_pkg::TOTAL_W] ? '1 : sum_wide[slcp_pkg::TOTAL_W-1:0];
        end else if (o_event.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sum   <= '0;
        end else begin
            r_valid <= n_valid;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    assign o_event.valid        = r_valid;
    assign o_event.event_kind   = r_cmd.kind;
    assign o_event.wait_samples = r_cmd.wait_samples;
    assign o_event.reg_addr     = r_cmd.reg_addr;
    assign o_event.reg_value    = r_cmd.reg_value;
    assign o_event.delay_total  = r_sum;
    assign o_event.bad_opcode   = r_cmd.bad_opcode;

endmodule

FILE: rtl/sound_log_command_parser.sv
// Top level of the sound-log command parser: front end, command queue and back end.
// Throughput: one byte per cycle, sustained, as long as the event sink keeps taking items.
// A byte that completes a command is written into the queue at the edge that accepts it
// and moves into the back end's output register, which offers its event, as soon as that
// register is empty or its event is being taken by the sink.
// Reset (synchronous, active low) returns the parser to expecting an opcode, clears the
// delay total and the stopped flag, and empties the queue and the output register.
`timescale 1ns / 1ps

module sound_log_command_parser #(
    parameter int QUEUE_DEPTH = slcp_pkg::QUEUE_DEPTH_D
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slcp_in_if.sink      i_byte,
    slcp_out_if.source   o_event
);

    // The front end decodes each byte against the current parse phase. Bytes that only
    // carry part of a command (a count byte or a register address) are held there; a
    // byte that completes a command pushes one decoded entry into the queue. After the
    // end-of-stream opcode or an unknown opcode the front end stops and swallows every
    // further byte, so the input never stalls from then on.
    logic                   push;
    logic                   pop;
    logic                   q_full;
    logic                   q_empty;
    slcp_pkg::t_cmd         front_cmd;
    slcp_pkg::t_cmd         queue_cmd;
    slcp_pkg::t_front_stat  front_stat;

    slcp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd),
        .o_stat   (front_stat)
    );

    // The queue decouples the two halves, so the front end keeps taking bytes while an
    // event waits at the output for the sink.
    slcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // The back end adds each wait into a saturating 32-bit total and presents every
    // event with the total as it stands after that event.
    slcp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (queue_cmd),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_event (o_event)
    );

    // The queue is never written when full nor read when empty.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("command popped from an empty queue");

    // A stopped parser produces no further commands.
    a_silent_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_stat.stopped |-> !push)
        else $error("command produced after the stream stopped");

    // The delay total never falls while the block runs.
    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event.valid && $past(o_event.valid) && $past(i_rst_n))
            |-> o_event.delay_total >= $past(o_event.delay_total))
        else $error("delay total decreased");

endmodule
